### hw/rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants for the PWM / quadrature encoder timer.
// ----------------------------------------------------------------------------
package pet_pkg;

    // sizes
    localparam int Channels   = 4;   // compare channels in use, 1 to 4
    localparam int PwmBits    = 4;   // width of the pwm output field
    localparam int CountBits  = 16;
    localparam int RegBits    = 17;
    localparam int CfgIdxBits = 3;

    // command codes carried by an input transfer
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ZERO  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // counting mode held in control bits 1:0
    localparam logic [1:0] MODE_TIMER = 2'd0;

    // configuration register indexes
    typedef enum logic [CfgIdxBits-1:0] {
        REG_PERIOD   = 3'd0,
        REG_PRESCALE = 3'd1,
        REG_DUTY1    = 3'd2,
        REG_DUTY2    = 3'd3,
        REG_DUTY3    = 3'd4,
        REG_DUTY4    = 3'd5,
        REG_CH_EN    = 3'd6,
        REG_CONTROL  = 3'd7
    } t_reg_idx;

    // settings the counter needs
    typedef struct packed {
        logic [CountBits-1:0] reload;
        logic [CountBits-1:0] pre_reload;
        logic [1:0]           mode;
        logic                 inv_a;
    } t_cnt_cfg;

    // counter state handed to the output stage
    typedef struct packed {
        logic                 pend;
        logic [CountBits-1:0] count;
        logic                 flag;
    } t_cnt_stat;

endpackage

### hw/rtl/pet_in_if.sv
// ----------------------------------------------------------------------------
// pet_in_if
// Input channel: one command with the sampled encoder levels per transfer.
// ----------------------------------------------------------------------------
interface pet_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       enc_a;
    logic       enc_b;

    modport source (output valid, output cmd, output enc_a, output enc_b, input ready);
    modport sink   (input valid, input cmd, input enc_a, input enc_b, output ready);
endinterface

### hw/rtl/pet_out_if.sv
// ----------------------------------------------------------------------------
// pet_out_if
// Result channel: counter value, pwm levels, update flag and interrupt.
// ----------------------------------------------------------------------------
interface pet_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] count;
    logic [3:0]  pwm_out;
    logic        update_flag;
    logic        irq;

    modport source (output valid, output count, output pwm_out, output update_flag,
                    output irq, input ready);
    modport sink   (input valid, input count, input pwm_out, input update_flag,
                    input irq, output ready);
endinterface

### hw/rtl/pet_cfg_regs.sv
// ----------------------------------------------------------------------------
// pet_cfg_regs
// Configuration registers, reload decode and registered compare thresholds.
// ----------------------------------------------------------------------------
module pet_cfg_regs
    import pet_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CfgIdxBits-1:0]               i_cfg_idx,
    input  logic [RegBits-1:0]                  i_cfg_wdata,
    output t_cnt_cfg                            o_cnt_cfg,
    output logic [Channels-1:0][CountBits-1:0]  o_cmp,
    output logic [PwmBits-1:0]                  o_ch_en,
    output logic                                o_irq_en
);

    logic [RegBits-1:0]   r_period;
    logic [RegBits-1:0]   r_prescale;
    logic [RegBits-1:0]   r_duty [4];
    logic [PwmBits-1:0]   r_ch_en;
    logic [3:0]           r_control;

    logic [Channels-1:0][CountBits-1:0] r_cmp;
    logic [Channels-1:0][CountBits-1:0] n_cmp;

    logic [RegBits-1:0]   period_m1;
    logic [RegBits-1:0]   prescale_m1;
    logic [RegBits-1:0]   duty_sat;
    logic [32:0]          cmp_prod;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= 17'h10000;
            r_prescale <= 17'h00001;
            r_duty[0]  <= '0;
            r_duty[1]  <= '0;
            r_duty[2]  <= '0;
            r_duty[3]  <= '0;
            r_ch_en    <= '0;
            r_control  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PERIOD:   r_period   <= i_cfg_wdata;
                REG_PRESCALE: r_prescale <= i_cfg_wdata;
                REG_DUTY1:    r_duty[0]  <= i_cfg_wdata;
                REG_DUTY2:    r_duty[1]  <= i_cfg_wdata;
                REG_DUTY3:    r_duty[2]  <= i_cfg_wdata;
                REG_DUTY4:    r_duty[3]  <= i_cfg_wdata;
                REG_CH_EN:    r_ch_en    <= i_cfg_wdata[PwmBits-1:0];
                REG_CONTROL:  r_control  <= i_cfg_wdata[3:0];
                default:      ;
            endcase
        end
    end

    // reload values wrap modulo 2^16
    always_comb begin
        period_m1   = r_period - 17'd1;
        prescale_m1 = r_prescale - 17'd1;
        o_cnt_cfg.reload     = period_m1[CountBits-1:0];
        o_cnt_cfg.pre_reload = prescale_m1[CountBits-1:0];
        o_cnt_cfg.mode       = r_control[1:0];
        o_cnt_cfg.inv_a      = r_control[2];
    end

    // compare threshold: floor(reload * duty), duty saturated at 1.0
    always_comb begin
        n_cmp = '0;
        for (int ch = 0; ch < Channels; ch++) begin
            duty_sat  = r_duty[ch][RegBits-1] ? 17'h10000 : r_duty[ch];
            cmp_prod  = 33'(o_cnt_cfg.reload) * 33'(duty_sat);
            n_cmp[ch] = cmp_prod[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp <= n_cmp;
    end

    assign o_cmp    = r_cmp;
    assign o_ch_en  = r_ch_en;
    assign o_irq_en = r_control[3];

endmodule

### hw/rtl/pet_counter.sv
// ----------------------------------------------------------------------------
// pet_counter
// Prescaler, main counter, quadrature decode and sticky update flag.
// ----------------------------------------------------------------------------
module pet_counter
    import pet_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cnt_cfg   i_cfg,
    input  logic       i_accept,
    input  logic [1:0] i_cmd,
    input  logic       i_enc_a,
    input  logic       i_enc_b,
    input  logic       i_take,
    output t_cnt_stat  o_stat
);

    logic [CountBits-1:0] r_pre;
    logic [CountBits-1:0] r_cnt;
    logic                 r_flag;
    logic                 r_last_a;
    logic                 r_last_b;
    logic                 r_pend;

    logic [CountBits-1:0] n_pre;
    logic [CountBits-1:0] n_cnt;
    logic                 n_flag;
    logic                 n_last_a;
    logic                 n_last_b;

    logic a_edge;
    logic b_edge;
    logic ea;
    logic step_up;
    logic step_dn;

    // next state for one accepted command
    always_comb begin
        n_pre    = r_pre;
        n_cnt    = r_cnt;
        n_flag   = r_flag;
        n_last_a = r_last_a;
        n_last_b = r_last_b;
        step_up  = 1'b0;
        step_dn  = 1'b0;
        a_edge   = i_enc_a != r_last_a;
        b_edge   = i_enc_b != r_last_b;
        ea       = i_enc_a ^ i_cfg.inv_a;

        if (i_accept) begin
            case (i_cmd)
                CMD_TICK: begin
                    if (i_cfg.mode == MODE_TIMER) begin
                        if (r_pre >= i_cfg.pre_reload) begin
                            n_pre   = '0;
                            step_up = 1'b1;
                        end else begin
                            n_pre = r_pre + 16'd1;
                        end
                    end else if (!(a_edge && b_edge)) begin
                        // both inputs moving at once is a glitch
                        if (a_edge && i_cfg.mode[1]) begin
                            step_up = ea != i_enc_b;
                            step_dn = ea == i_enc_b;
                        end else if (b_edge && i_cfg.mode[0]) begin
                            step_up = i_enc_b == ea;
                            step_dn = i_enc_b != ea;
                        end
                    end
                    n_last_a = i_enc_a;
                    n_last_b = i_enc_b;
                end
                CMD_ZERO:  n_cnt  = '0;
                CMD_CLEAR: n_flag = 1'b0;
                default:   ;
            endcase
        end

        // counter step with wrap at the reload value
        if (step_up) begin
            if (r_cnt >= i_cfg.reload) begin
                n_cnt  = '0;
                n_flag = 1'b1;
            end else begin
                n_cnt = r_cnt + 16'd1;
            end
        end else if (step_dn) begin
            if (r_cnt == '0) begin
                n_cnt  = i_cfg.reload;
                n_flag = 1'b1;
            end else begin
                n_cnt = r_cnt - 16'd1;
            end
        end
    end

    // state registers and pending result marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre    <= '0;
            r_cnt    <= '0;
            r_flag   <= 1'b0;
            r_last_a <= 1'b0;
            r_last_b <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_pre    <= n_pre;
            r_cnt    <= n_cnt;
            r_flag   <= n_flag;
            r_last_a <= n_last_a;
            r_last_b <= n_last_b;
            if (i_accept) begin
                r_pend <= 1'b1;
            end else if (i_take) begin
                r_pend <= 1'b0;
            end
        end
    end

    assign o_stat.pend  = r_pend;
    assign o_stat.count = r_cnt;
    assign o_stat.flag  = r_flag;

endmodule

### hw/rtl/pet_out_stage.sv
// ----------------------------------------------------------------------------
// pet_out_stage
// PWM compare and result register feeding the output channel.
// ----------------------------------------------------------------------------
module pet_out_stage
    import pet_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cnt_stat                          i_stat,
    input  logic [Channels-1:0][CountBits-1:0] i_cmp,
    input  logic [PwmBits-1:0]                 i_ch_en,
    input  logic                               i_irq_en,
    output logic                               o_take,
    pet_out_if.source                          o_out
);

    logic                 r_valid;
    logic [CountBits-1:0] r_count;
    logic [PwmBits-1:0]   r_pwm;
    logic                 r_flag;
    logic                 r_irq;

    logic [PwmBits-1:0]   n_pwm;

    // result register is free when empty or being drained
    assign o_take = !r_valid || o_out.ready;

    // pwm mode 1: high while count is below the threshold
    always_comb begin
        n_pwm = '0;
        for (int ch = 0; ch < Channels; ch++) begin
            n_pwm[ch] = i_ch_en[ch] && (i_stat.count < i_cmp[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_stat.pend;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_stat.pend) begin
            r_count <= i_stat.count;
            r_pwm   <= n_pwm;
            r_flag  <= i_stat.flag;
            r_irq   <= i_stat.flag && i_irq_en;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.count       = r_count;
    assign o_out.pwm_out     = r_pwm;
    assign o_out.update_flag = r_flag;
    assign o_out.irq         = r_irq;

endmodule

### hw/rtl/pwm_encoder_timer.sv
// ----------------------------------------------------------------------------
// pwm_encoder_timer
// 16-bit timer with prescaler, four pwm compare channels and quadrature
// encoder counting.
// ----------------------------------------------------------------------------
// One command is taken per clock cycle, back to back, while the output
// channel does not hold back its results, and each gives one result. A
// command updates the prescaler, counter and update flag at the transfer
// edge and marks its result pending; the result register loads it once it
// is free, and from there the result transfers on the output channel. The
// input stays ready while the counter holds no result yet to be loaded, or
// while the result register is empty or being drained. Compare thresholds
// are the product of reload and duty, registered from the config registers.
// ----------------------------------------------------------------------------
module pwm_encoder_timer
    import pet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pet_in_if.sink                i_in,
    pet_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_idx,
    input  logic [RegBits-1:0]    i_cfg_wdata
);

    t_cnt_cfg                           cnt_cfg;
    t_cnt_stat                          cnt_stat;
    logic [Channels-1:0][CountBits-1:0] cmp;
    logic [PwmBits-1:0]                 ch_en;
    logic                               irq_en;
    logic                               take;
    logic                               accept;

    // input handshake
    assign i_in.ready = !cnt_stat.pend || take;
    assign accept     = i_in.valid && i_in.ready;

    pet_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cnt_cfg   (cnt_cfg),
        .o_cmp       (cmp),
        .o_ch_en     (ch_en),
        .o_irq_en    (irq_en)
    );

    pet_counter u_counter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cnt_cfg),
        .i_accept (accept),
        .i_cmd    (i_in.cmd),
        .i_enc_a  (i_in.enc_a),
        .i_enc_b  (i_in.enc_b),
        .i_take   (take),
        .o_stat   (cnt_stat)
    );

    pet_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (cnt_stat),
        .i_cmp    (cmp),
        .i_ch_en  (ch_en),
        .i_irq_en (irq_en),
        .o_take   (take),
        .o_out    (o_out)
    );

endmodule
